@@ sv/zobrist_position_hash_assert.svh @@
// ----------------------------------------------------------------------------
// zobrist position hash assertion macros
// concurrent checks on clk_i with rst_ni held low masking them
// ----------------------------------------------------------------------------
`ifndef ZOBRIST_POSITION_HASH_ASSERT_SVH
`define ZOBRIST_POSITION_HASH_ASSERT_SVH

`ifndef SYNTH

// condition implies consequence in the same cycle
`define ZPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ZPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ZPH_ASSERT_IMP(lbl, ante, cons, msg)
`define ZPH_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/zph_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_pkg
// shared types, generator constants and the xorshift step
// ----------------------------------------------------------------------------
package zph_pkg;

  typedef logic [63:0] key_t;

  // xorshift64* generator constants
  localparam key_t GEN_MULT   = 64'd2685821657736338717;
  localparam key_t RESET_SEED = 64'd1;
  localparam int   SHIFT_A    = 12;
  localparam int   SHIFT_B    = 25;
  localparam int   SHIFT_C    = 27;

  // en passant file is the square modulo eight
  localparam int   EP_FILE_W  = 3;

  // input item payload
  typedef struct packed {
    logic [5:0] square;
    logic [3:0] piece;
    logic       last;
    logic       black_to_move;
    logic [3:0] castling_rights;
    logic       ep_valid;
    logic [5:0] ep_square;
  } in_item_t;

  // result item payload
  typedef struct packed {
    key_t hash;
  } out_item_t;

  // per item flags held while the key reads are in flight
  typedef struct packed {
    logic piece_hit;
    logic last;
    logic black;
    logic castle_hit;
    logic ep_hit;
  } lookup_ctrl_t;

  // one xorshift state step
  function automatic key_t xorshift_step(input key_t x);
    key_t y;
    y = x ^ (x >> SHIFT_A);
    y = y ^ (y << SHIFT_B);
    y = y ^ (y >> SHIFT_C);
    return y;
  endfunction

endpackage

@@ sv/zph_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_stream_if
// valid/ready channel carrying one item payload
// ----------------------------------------------------------------------------
interface zph_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/zph_keygen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_keygen
// xorshift64* key generator, one key per cycle through a split multiplier
// ----------------------------------------------------------------------------
module zph_keygen #(
  parameter int TABLE_SIZE = 857,
  parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  zph_pkg::key_t     seed_i,
  output logic              key_we_o,
  output logic [IDX_W-1:0]  key_idx_o,
  output zph_pkg::key_t     key_o,
  output logic              busy_o
);
  import zph_pkg::*;

  localparam logic [31:0] MultLo = GEN_MULT[31:0];
  localparam logic [31:0] MultHi = GEN_MULT[63:32];

  logic             run_q;
  logic [IDX_W-1:0] cnt_q;
  key_t             x_q;
  logic             v0_q, v1_q, v2_q;
  logic [IDX_W-1:0] i0_q, i1_q, i2_q;
  logic [63:0]      p_ll_q;
  logic [31:0]      p_lh_q, p_hl_q;
  key_t             key_q;

  // step sequencer and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b1;
      cnt_q <= '0;
      x_q   <= RESET_SEED;
      v0_q  <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
      x_q   <= seed_i;
      v0_q  <= 1'b0;
    end else if (run_q) begin
      x_q   <= xorshift_step(x_q);
      v0_q  <= 1'b1;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == IDX_W'(TABLE_SIZE - 1)) begin
        run_q <= 1'b0;
      end
    end else begin
      v0_q <= 1'b0;
    end
  end

  // index travels with the state
  always_ff @(posedge clk_i) begin
    if (run_q) begin
      i0_q <= cnt_q;
    end
  end

  // multiplier stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (start_i) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // partial products, then the final sum modulo 2^64
  always_ff @(posedge clk_i) begin
    p_ll_q <= x_q[31:0] * MultLo;
    p_lh_q <= 32'(x_q[31:0] * MultHi);
    p_hl_q <= 32'(x_q[63:32] * MultLo);
    i1_q   <= i0_q;
    key_q  <= p_ll_q + {p_lh_q + p_hl_q, 32'b0};
    i2_q   <= i1_q;
  end

  assign key_we_o  = v2_q;
  assign key_idx_o = i2_q;
  assign key_o     = key_q;
  assign busy_o    = run_q | v0_q | v1_q | v2_q;

endmodule

@@ sv/zph_keymem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_keymem
// piece key memory, castling and file key memory, and the side key register
// ----------------------------------------------------------------------------
module zph_keymem #(
  parameter int PIECE_DEPTH = 832,
  parameter int AUX_DEPTH   = 24,
  parameter int IDX_W       = 10,
  parameter int PA_W        = $clog2(PIECE_DEPTH),
  parameter int AUX_W       = $clog2(AUX_DEPTH)
) (
  input  logic              clk_i,
  input  logic              key_we_i,
  input  logic [IDX_W-1:0]  key_idx_i,
  input  zph_pkg::key_t     key_i,
  input  logic              rd_en_i,
  input  logic [PA_W-1:0]   piece_addr_i,
  input  logic [AUX_W-1:0]  castle_addr_i,
  input  logic [AUX_W-1:0]  file_addr_i,
  output zph_pkg::key_t     piece_key_o,
  output zph_pkg::key_t     castle_key_o,
  output zph_pkg::key_t     file_key_o,
  output zph_pkg::key_t     side_key_o
);
  import zph_pkg::*;

  key_t             piece_mem [PIECE_DEPTH];
  key_t             aux_mem   [AUX_DEPTH];
  key_t             side_q;
  key_t             piece_rd_q, castle_rd_q, file_rd_q;
  logic             piece_we, side_we, aux_we;
  logic [IDX_W-1:0] aux_off;

  // fill index decode: pieces, side key, then castling and file keys
  assign aux_off  = key_idx_i - IDX_W'(PIECE_DEPTH + 1);
  assign piece_we = key_we_i && (key_idx_i < IDX_W'(PIECE_DEPTH));
  assign side_we  = key_we_i && (key_idx_i == IDX_W'(PIECE_DEPTH));
  assign aux_we   = key_we_i && (key_idx_i > IDX_W'(PIECE_DEPTH));

  // piece key memory
  always_ff @(posedge clk_i) begin
    if (piece_we) begin
      piece_mem[key_idx_i[PA_W-1:0]] <= key_i;
    end
    if (rd_en_i) begin
      piece_rd_q <= piece_mem[piece_addr_i];
    end
  end

  // castling and file key memory, two read ports
  always_ff @(posedge clk_i) begin
    if (aux_we) begin
      aux_mem[aux_off[AUX_W-1:0]] <= key_i;
    end
    if (rd_en_i) begin
      castle_rd_q <= aux_mem[castle_addr_i];
      file_rd_q   <= aux_mem[file_addr_i];
    end
  end

  // side to move key
  always_ff @(posedge clk_i) begin
    if (side_we) begin
      side_q <= key_i;
    end
  end

  assign piece_key_o  = piece_rd_q;
  assign castle_key_o = castle_rd_q;
  assign file_key_o   = file_rd_q;
  assign side_key_o   = side_q;

endmodule

@@ sv/zobrist_position_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zobrist_position_hash
// zobrist hash of a chess position streamed one square per item
// ----------------------------------------------------------------------------
// Squares stream in at one item per clock unless the key memory is being
// refilled or a last item waits on a full output. Each item reads its key
// from the synchronous key memory at the accepting edge and is folded into
// the 64-bit accumulator on the next edge; on the item flagged last the side,
// castling and en passant keys are read in the same cycle and the hash is
// registered once the output holds no untaken hash. After reset and after
// every seed write the key memory is refilled by the xorshift64* generator
// at one key per cycle, set by the generator's single write into the memory;
// input ready stays low until the last key is written. Writing the seed
// keeps a partly accumulated hash.
module zobrist_position_hash #(
  parameter int SQUARES       = 64,
  parameter int PIECE_CODES   = 13,
  parameter int CASTLE_STATES = 16,
  parameter int FILES         = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              seed_we_i,
  input  zph_pkg::key_t     seed_i,
  zph_stream_if.sink        in_i,
  zph_stream_if.source      out_o
);
  import zph_pkg::*;

  localparam int PieceDepth = SQUARES * PIECE_CODES;
  localparam int AuxDepth   = CASTLE_STATES + FILES;
  localparam int TableSize  = PieceDepth + 1 + AuxDepth;
  localparam int IdxW       = $clog2(TableSize);
  localparam int PaW        = $clog2(PieceDepth);
  localparam int AuxW       = $clog2(AuxDepth);

  in_item_t                item;
  logic                    busy;
  logic                    key_we;
  logic [IdxW-1:0]         key_idx;
  key_t                    key_val;
  logic                    accept, adv, in_ready;
  lookup_ctrl_t            ctrl_d, a_q;
  logic                    a_valid_q;
  logic [PaW-1:0]          piece_addr;
  logic [AuxW-1:0]         castle_addr, file_addr;
  logic [EP_FILE_W-1:0]    ep_file;
  key_t                    piece_key, castle_key, file_key, side_key;
  key_t                    contrib;
  key_t                    acc_q;
  logic                    out_valid_q;
  key_t                    out_hash_q;

  assign item = in_i.data;

  // key generator
  zph_keygen #(
    .TABLE_SIZE (TableSize),
    .IDX_W      (IdxW)
  ) u_keygen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (seed_we_i),
    .seed_i    (seed_i),
    .key_we_o  (key_we),
    .key_idx_o (key_idx),
    .key_o     (key_val),
    .busy_o    (busy)
  );

  // lookup decode for the incoming item
  assign ep_file = item.ep_square[EP_FILE_W-1:0];
  always_comb begin
    ctrl_d.piece_hit  = (32'(item.square) < 32'(SQUARES)) &&
                        (32'(item.piece) < 32'(PIECE_CODES));
    ctrl_d.last       = item.last;
    ctrl_d.black      = item.black_to_move;
    ctrl_d.castle_hit = 32'(item.castling_rights) < 32'(CASTLE_STATES);
    ctrl_d.ep_hit     = item.ep_valid && (32'(ep_file) < 32'(FILES));
  end

  assign piece_addr  = ctrl_d.piece_hit ?
                       PaW'(PaW'(item.square) * PaW'(PIECE_CODES) + PaW'(item.piece)) : '0;
  assign castle_addr = ctrl_d.castle_hit ? AuxW'(item.castling_rights) : '0;
  assign file_addr   = ctrl_d.ep_hit ? AuxW'(AuxW'(CASTLE_STATES) + AuxW'(ep_file)) : '0;

  // key memories
  zph_keymem #(
    .PIECE_DEPTH (PieceDepth),
    .AUX_DEPTH   (AuxDepth),
    .IDX_W       (IdxW),
    .PA_W        (PaW),
    .AUX_W       (AuxW)
  ) u_keymem (
    .clk_i         (clk_i),
    .key_we_i      (key_we),
    .key_idx_i     (key_idx),
    .key_i         (key_val),
    .rd_en_i       (accept),
    .piece_addr_i  (piece_addr),
    .castle_addr_i (castle_addr),
    .file_addr_i   (file_addr),
    .piece_key_o   (piece_key),
    .castle_key_o  (castle_key),
    .file_key_o    (file_key),
    .side_key_o    (side_key)
  );

  // handshake: the lookup stage moves on unless a last item meets a full output
  assign adv      = a_valid_q && (!a_q.last || !out_valid_q || out_o.ready);
  assign in_ready = !busy && (!a_valid_q || adv);
  assign accept   = in_i.valid && in_ready;

  // lookup stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (adv) begin
      a_valid_q <= 1'b0;
    end
  end

  // lookup stage flags
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= ctrl_d;
    end
  end

  // keys selected for this item
  always_comb begin
    contrib = a_q.piece_hit ? piece_key : '0;
    if (a_q.last) begin
      contrib = contrib ^ (a_q.black ? side_key : '0)
                        ^ (a_q.castle_hit ? castle_key : '0)
                        ^ (a_q.ep_hit ? file_key : '0);
    end
  end

  // accumulator and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv && a_q.last) begin
        acc_q       <= '0;
        out_valid_q <= 1'b1;
      end else begin
        if (adv) begin
          acc_q <= acc_q ^ contrib;
        end
        if (out_o.ready) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // hash payload
  always_ff @(posedge clk_i) begin
    if (adv && a_q.last) begin
      out_hash_q <= acc_q ^ contrib;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.data.hash = out_hash_q;

  // checks
  `include "zobrist_position_hash_assert.svh"

  `ZPH_ASSERT_IMP(a_fill_idx_range, key_we, 32'(key_idx) < 32'(TableSize), "fill index out of range")
  `ZPH_ASSERT_IMP(a_no_overwrite, out_valid_q && !out_o.ready, !(adv && a_q.last), "hash overwritten")
  `ZPH_ASSERT_NXT(a_acc_cleared, adv && a_q.last, acc_q == '0, "accumulator not cleared")

endmodule
